// ----- rtl/imau_pkg.sv -----
// imau_pkg: shared types and codes for the integer matrix arithmetic unit
// used by the top level integer_matrix_arithmetic_unit
`default_nettype none
package imau_pkg;

  typedef enum logic [1:0] {
    OPC_WRITE_A = 2'd0,
    OPC_WRITE_B = 2'd1,
    OPC_COMPUTE = 2'd2,
    OPC_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_NEG = 2'd3
  } operation_e;

  typedef enum logic [2:0] {
    REG_ROWS_A    = 3'd0,
    REG_COLS_A    = 3'd1,
    REG_ROWS_B    = 3'd2,
    REG_COLS_B    = 3'd3,
    REG_OPERATION = 3'd4
  } reg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] result;
    logic               status;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/imau_ram.sv -----
// imau_ram: generic single-port write, single read RAM with registered read
// no dependencies
`default_nettype none
module imau_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/imau_cell.sv -----
// imau_cell: one lane cell; holds a running sum, accumulates a product of
// the broadcast a element and its own b element, shifts sums along the chain
`default_nettype none
module imau_cell #(
  parameter int ElemWidth = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 clr_i,
  input  wire logic                 mac_i,
  input  wire logic                 shift_i,
  input  wire logic [ElemWidth-1:0] a_i,
  input  wire logic [ElemWidth-1:0] b_i,
  input  wire logic [ElemWidth-1:0] sum_i,
  output logic      [ElemWidth-1:0] sum_o
);
  logic [ElemWidth-1:0] sum_q, sum_d, prod;

  assign prod = ElemWidth'(a_i * b_i);

  // clear, accumulate, or shift the sum chain toward the output
  always_comb begin
    sum_d = sum_q;
    if (clr_i) sum_d = '0;
    else if (mac_i) sum_d = sum_q + prod;
    else if (shift_i) sum_d = sum_i;
  end

  always_ff @(posedge clk_i) sum_q <= sum_d;
  assign sum_o = sum_q;
endmodule
`default_nettype wire

// ----- rtl/integer_matrix_arithmetic_unit.sv -----
// integer_matrix_arithmetic_unit: top level, control, stores and cell row
// depends on imau_pkg, imau_ram, imau_cell
//
// Usage: items arrive on in_valid_i/in_ready_o. Write A / write B items store
// one element and are accepted back to back; writes outside the MAX_DIM grid
// are dropped. A compute item produces the selected matrix in row-major order
// on out_valid_o/out_ready_i, last set on the final item; a shape mismatch
// gives one item with status set and no data, loaded in the error state once
// the output register is free. A row of MAX_DIM cells computes one output row.
// For each inner step k the sequencer reads row k of B into a shift line,
// waits for the last read to land and then accumulates A[i][k]; after the
// last k the row of sums shifts out as cols_b result items. Add, subtract
// and negate read the stores, wait for the read data and emit one element at
// a time. in_ready_o stays low until the last result is in the output register.
// A full output register that the receiver leaves unaccepted stalls emission.
// Reset clears control state and sets the shape registers to 1 and the
// operation to multiply; store contents are undefined until written.
`default_nettype none
module integer_matrix_arithmetic_unit #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire imau_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output imau_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [3:0]           cfg_data_i
);
  localparam int DW = $clog2(MAX_DIM);
  localparam int AW = 2 * DW;
  localparam int Depth = 1 << AW;
  localparam int CW = DW + 1;

  logic [3:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [1:0] op_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= 4'd1; cols_a_q <= 4'd1; rows_b_q <= 4'd1; cols_b_q <= 4'd1;
      op_q <= imau_pkg::OP_MUL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        imau_pkg::REG_ROWS_A:    rows_a_q <= cfg_data_i;
        imau_pkg::REG_COLS_A:    cols_a_q <= cfg_data_i;
        imau_pkg::REG_ROWS_B:    rows_b_q <= cfg_data_i;
        imau_pkg::REG_COLS_B:    cols_b_q <= cfg_data_i;
        imau_pkg::REG_OPERATION: op_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..MAX_DIM
  function automatic logic [CW-1:0] clampd(input logic [3:0] d);
    if (d == 4'd0) return CW'(1);
    if (32'(d) > MAX_DIM) return CW'(MAX_DIM);
    return CW'(d);
  endfunction

  logic [CW-1:0] ra, ca, rb, cb, nr, nc;
  logic mismatch;
  assign ra = clampd(rows_a_q);
  assign ca = clampd(cols_a_q);
  assign rb = clampd(rows_b_q);
  assign cb = clampd(cols_b_q);

  always_comb begin
    nr = ra; nc = ca; mismatch = 1'b0;
    unique case (imau_pkg::operation_e'(op_q))
      imau_pkg::OP_MUL: begin nc = cb; mismatch = (ca != rb); end
      imau_pkg::OP_ADD, imau_pkg::OP_SUB: mismatch = (ra != rb) || (ca != cb);
      default: ;
    endcase
  end

  // element value kept at ELEM_WIDTH bits
  logic [ELEM_WIDTH-1:0] wval;
  assign wval = ELEM_WIDTH'(in_data_i.value);

  imau_pkg::state_e state_q, state_d;
  logic [DW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic rd_vld_q, rd_vld_d;
  logic ovalid_q, ovalid_d;
  imau_pkg::out_item_t odata_q, odata_d;

  logic in_fire, out_free, wr_ok;
  logic [AW-1:0] a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;
  logic clr, mac, shift;
  logic [ELEM_WIDTH-1:0] sums [MAX_DIM];
  logic [ELEM_WIDTH-1:0] ew_res;

  assign in_ready_o = (state_q == imau_pkg::ST_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_free = !ovalid_q || out_ready_i;

  // writes outside the MAX_DIM x MAX_DIM grid are dropped
  assign wr_ok = (32'(in_data_i.row) < MAX_DIM) && (32'(in_data_i.col) < MAX_DIM);

  // stores; write addresses {row, col} from the input item
  imau_ram #(.Width(ELEM_WIDTH), .Depth(Depth)) u_store_a (
    .clk_i, .we_i(in_fire && wr_ok && in_data_i.opcode == imau_pkg::OPC_WRITE_A),
    .waddr_i({in_data_i.row[DW-1:0], in_data_i.col[DW-1:0]}), .wdata_i(wval),
    .raddr_i(a_raddr), .rdata_o(a_rdata));
  imau_ram #(.Width(ELEM_WIDTH), .Depth(Depth)) u_store_b (
    .clk_i, .we_i(in_fire && wr_ok && in_data_i.opcode == imau_pkg::OPC_WRITE_B),
    .waddr_i({in_data_i.row[DW-1:0], in_data_i.col[DW-1:0]}), .wdata_i(wval),
    .raddr_i(b_raddr), .rdata_o(b_rdata));

  // cell row: cell c takes b element of column c; a is broadcast.
  // after accumulation the sums shift toward cell 0 for emission.
  logic [ELEM_WIDTH-1:0] brow_q [MAX_DIM];
  genvar g;
  for (g = 0; g < MAX_DIM; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] nxt;
    if (g == MAX_DIM - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = sums[g+1];
    end
    imau_cell #(.ElemWidth(ELEM_WIDTH)) u_cell (
      .clk_i, .clr_i(clr), .mac_i(mac), .shift_i(shift),
      .a_i(a_rdata), .b_i(brow_q[g]), .sum_i(nxt), .sum_o(sums[g]));
  end

  // b row buffer: the cells need all of row k of B at once, loaded one
  // element per cycle into a shift line before each accumulate step
  logic bsh;
  always_ff @(posedge clk_i) begin
    if (bsh) begin
      for (int c = 0; c < MAX_DIM - 1; c++) brow_q[c] <= brow_q[c+1];
      brow_q[MAX_DIM-1] <= b_rdata;
    end
  end

  assign ew_res = (op_q == imau_pkg::OP_ADD) ? a_rdata + b_rdata :
                  (op_q == imau_pkg::OP_SUB) ? a_rdata - b_rdata : '0 - a_rdata;

  function automatic logic signed [31:0] sx(input logic [ELEM_WIDTH-1:0] v);
    return 32'(signed'(v));
  endfunction

  // sequencer; multiply per row i: for each k, load B row k into the line
  // (MAX_DIM reads), then one accumulate with A[i][k]; then emit nc sums
  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; k_d = k_q; cnt_d = cnt_q;
    rd_vld_d = 1'b0;
    ovalid_d = ovalid_q && !out_ready_i; odata_d = odata_q;
    a_raddr = {i_q, k_q}; b_raddr = {k_q, j_q};
    clr = 1'b0; mac = 1'b0; shift = 1'b0; bsh = 1'b0;
    unique case (state_q)
      imau_pkg::ST_IDLE: begin
        if (in_fire && in_data_i.opcode == imau_pkg::OPC_COMPUTE) begin
          i_d = '0; j_d = '0; k_d = '0; cnt_d = '0; clr = 1'b1;
          if (mismatch) state_d = imau_pkg::ST_ERR;
          else if (op_q == imau_pkg::OP_MUL) state_d = imau_pkg::ST_LOAD;
          else state_d = imau_pkg::ST_MAC;
        end
      end
      imau_pkg::ST_ERR: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d = '{out_row: 3'd0, out_col: 3'd0, result: 32'sd0,
                      status: 1'b1, last: 1'b1};
          state_d = imau_pkg::ST_IDLE;
        end
      end
      imau_pkg::ST_LOAD: begin
        // read B[k][cnt]; data lands next cycle into the line
        b_raddr = {k_q, cnt_q[DW-1:0]};
        a_raddr = {i_q, k_q};
        bsh = rd_vld_q;
        if (cnt_q < CW'(MAX_DIM)) begin
          rd_vld_d = 1'b1; cnt_d = cnt_q + CW'(1);
        end else if (!rd_vld_q) begin
          mac = 1'b1; cnt_d = '0;
          if (CW'(k_q) + CW'(1) == ca) begin
            k_d = '0; j_d = '0; state_d = imau_pkg::ST_EMIT;
          end else begin
            k_d = k_q + DW'(1);
          end
        end
      end
      imau_pkg::ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d = '{out_row: 3'(i_q), out_col: 3'(j_q), result: sx(sums[0]),
                      status: 1'b0,
                      last: (CW'(i_q) + CW'(1) == nr) && (CW'(j_q) + CW'(1) == nc)};
          shift = 1'b1;
          if (CW'(j_q) + CW'(1) == nc) begin
            j_d = '0; clr = 1'b0;
            if (CW'(i_q) + CW'(1) == nr) state_d = imau_pkg::ST_IDLE;
            else begin i_d = i_q + DW'(1); state_d = imau_pkg::ST_LOAD; end
          end else j_d = j_q + DW'(1);
        end
      end
      imau_pkg::ST_MAC: begin
        // elementwise: issue read, wait for the read data, emit once the output is free
        a_raddr = {i_q, j_q}; b_raddr = {i_q, j_q};
        if (!rd_vld_q && cnt_q == '0) begin
          rd_vld_d = 1'b1; cnt_d = CW'(1);
        end else if (rd_vld_q) begin
          rd_vld_d = 1'b0;
        end else if (out_free) begin
          ovalid_d = 1'b1; cnt_d = '0;
          odata_d = '{out_row: 3'(i_q), out_col: 3'(j_q), result: sx(ew_res),
                      status: 1'b0,
                      last: (CW'(i_q) + CW'(1) == nr) && (CW'(j_q) + CW'(1) == nc)};
          if (CW'(j_q) + CW'(1) == nc) begin
            j_d = '0;
            if (CW'(i_q) + CW'(1) == nr) state_d = imau_pkg::ST_IDLE;
            else i_d = i_q + DW'(1);
          end else j_d = j_q + DW'(1);
        end else begin
          // hold read address so data stays valid
          rd_vld_d = 1'b0;
        end
      end
      default: state_d = imau_pkg::ST_IDLE;
    endcase
    if (state_q == imau_pkg::ST_EMIT && state_d == imau_pkg::ST_LOAD) begin
      // shifting in zeros leaves the row cleared after nc shifts only if
      // nc == MAX_DIM, so clear explicitly
      clr = 1'b1; shift = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imau_pkg::ST_IDLE;
      ovalid_q <= 1'b0; rd_vld_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; cnt_q <= '0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d; rd_vld_q <= rd_vld_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) odata_q <= odata_d;

  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;
endmodule
`default_nettype wire
